// ----- rtl/core/spd_pkg.sv -----
// spd_pkg: shared types and constants for the syn port scan detector
// beat payload structs, register indexes and reset values; no dependencies
`timescale 1ns / 1ps

package spd_pkg;

   // default table sizes
   localparam int NUM_TRACKERS_DEF      = 128;
   localparam int PORTS_PER_TRACKER_DEF = 128;

   // configuration register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SECONDS  = 1'd1;

   localparam logic [7:0]  THRESHOLD_RESET = 8'd10;
   localparam logic [15:0] WINDOW_RESET    = 16'd5;

   // one syn event
   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] dst_port;
      logic [31:0] time_sec;
   } spd_req_type;

   // one result beat
   typedef struct packed {
      logic       alert;
      logic       tracked;
      logic [7:0] unique_ports;
      logic [6:0] slot_index;
   } spd_rsp_type;

endpackage

// ----- rtl/core/spd_ram.sv -----
// spd_ram: simple dual port ram, one write and one registered read per cycle
// used for the tracker records and the per-tracker port sets; no dependencies
`timescale 1ns / 1ps

module spd_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 128
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                       rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/core/syn_port_scan_detector_top.sv -----
// syn_port_scan_detector_top: syn port scan detector, one event at a time
// processing: a slot scan over the valid prefix of the tracker table (one record read a cycle),
//   then a port-set scan of the matched tracker (one port a cycle), then the result beat
// one event at a time; the next event is taken while the result waits
// reset: synchronous; tracker table empties at once through the fill count, no clearing pass
// depends on spd_pkg and spd_ram
`timescale 1ns / 1ps

module syn_port_scan_detector_top
   import spd_pkg::*;
#(
   parameter int NUM_TRACKERS      = NUM_TRACKERS_DEF,
   parameter int PORTS_PER_TRACKER = PORTS_PER_TRACKER_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spd_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spd_rsp_type           rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SLOT_W   = (NUM_TRACKERS > 1) ? $clog2(NUM_TRACKERS) : 1;
   localparam int SCAN_W   = $clog2(NUM_TRACKERS + 1);
   localparam int CNT_W    = $clog2(PORTS_PER_TRACKER + 1);
   localparam int PDEPTH   = NUM_TRACKERS * PORTS_PER_TRACKER;
   localparam int PADDR_W  = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

   // tracker record as kept in the record ram
   typedef struct packed {
      logic [31:0]      src;
      logic [31:0]      dst;
      logic [31:0]      start;
      logic [CNT_W-1:0] count;
      logic             alerted;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT,
      ST_WIN,
      ST_PORT,
      ST_UPD
   } state_type;

   state_type          state_ff, state_in;
   logic [SCAN_W-1:0]  fill_ff, fill_in;
   logic [SCAN_W-1:0]  scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [SLOT_W-1:0]  cmp_slot_ff, cmp_slot_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               full_ff, full_in;
   spd_req_type        item_ff, item_in;
   logic [31:0]        start_ff, start_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               alerted_ff, alerted_in;
   logic [PADDR_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0]   pidx_ff, pidx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   spd_rsp_type        rsp_ff, rsp_in;
   logic [7:0]         thr_ff;
   logic [15:0]        win_ff;

   // ram ports
   logic               rec_wr_en;
   logic [SLOT_W-1:0]  rec_wr_addr;
   rec_type            rec_wr_data;
   logic [SLOT_W-1:0]  rec_rd_addr;
   rec_type            rec_rd_data;
   logic               port_wr_en;
   logic [PADDR_W-1:0] port_wr_addr;
   logic [15:0]        port_wr_data;
   logic [PADDR_W-1:0] port_rd_addr;
   logic [15:0]        port_rd_data;

   logic [32:0]        elapsed;
   logic               expired;
   logic               hit_alert;
   logic               pair_match;

   spd_ram #(
      .DATA_W (REC_W),
      .DEPTH  (NUM_TRACKERS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .rd_addr (rec_rd_addr),
      .rd_data (rec_rd_data)
   );

   spd_ram #(
      .DATA_W (16),
      .DEPTH  (PDEPTH)
   ) u_port_ram (
      .clock   (clock),
      .wr_en   (port_wr_en),
      .wr_addr (port_wr_addr),
      .wr_data (port_wr_data),
      .rd_addr (port_rd_addr),
      .rd_data (port_rd_data)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
         win_ff <= WINDOW_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ALERT_THRESHOLD: thr_ff <= csr_wdata[7:0];
            CSR_WINDOW_SECONDS:  win_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // window check: signed difference of the two timestamps
   assign elapsed    = {1'b0, item_ff.time_sec} - {1'b0, start_ff};
   assign expired    = !elapsed[32] && (elapsed[31:0] > {16'd0, win_ff});
   assign hit_alert  = (32'(count_ff) >= 32'(thr_ff)) && !alerted_ff;
   assign pair_match = (rec_rd_data.src == item_ff.src_addr) &&
                       (rec_rd_data.dst == item_ff.dst_addr);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      cmp_slot_in  = cmp_slot_ff;
      slot_in      = slot_ff;
      full_in      = full_ff;
      item_in      = item_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      alerted_in   = alerted_ff;
      base_in      = base_ff;
      pidx_in      = pidx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      rec_wr_en            = 1'b0;
      rec_wr_addr          = slot_ff;
      rec_wr_data.src      = item_ff.src_addr;
      rec_wr_data.dst      = item_ff.dst_addr;
      rec_wr_data.start    = start_ff;
      rec_wr_data.count    = count_ff;
      rec_wr_data.alerted  = alerted_ff | hit_alert;
      rec_rd_addr          = scan_ff[SLOT_W-1:0];
      port_wr_en           = 1'b0;
      port_rd_addr         = base_ff + PADDR_W'(pidx_ff);
      port_wr_addr         = port_rd_addr;
      port_wr_data         = item_ff.dst_port;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               scan_in  = '0;
               pend_in  = 1'b0;
               state_in = ST_SLOT;
            end
         end
         // walk the valid prefix of the table, one record read a cycle
         ST_SLOT: begin
            if (pend_ff && pair_match) begin
               slot_in    = cmp_slot_ff;
               start_in   = rec_rd_data.start;
               count_in   = rec_rd_data.count;
               alerted_in = rec_rd_data.alerted;
               full_in    = 1'b0;
               state_in   = ST_WIN;
            end else if (scan_ff == fill_ff) begin
               if (fill_ff == SCAN_W'(NUM_TRACKERS)) begin
                  full_in  = 1'b1;
                  state_in = ST_UPD;
               end else begin
                  slot_in    = fill_ff[SLOT_W-1:0];
                  start_in   = item_ff.time_sec;
                  count_in   = '0;
                  alerted_in = 1'b0;
                  full_in    = 1'b0;
                  fill_in    = fill_ff + SCAN_W'(1);
                  state_in   = ST_WIN;
               end
            end else begin
               cmp_slot_in = scan_ff[SLOT_W-1:0];
               scan_in     = scan_ff + SCAN_W'(1);
               pend_in     = 1'b1;
            end
         end
         // window expiry and port-set base address
         ST_WIN: begin
            if (expired) begin
               count_in   = '0;
               alerted_in = 1'b0;
               start_in   = item_ff.time_sec;
            end
            base_in  = PADDR_W'(slot_ff * PORTS_PER_TRACKER);
            pidx_in  = '0;
            pend_in  = 1'b0;
            state_in = ST_PORT;
         end
         // search the port set, append on a miss while there is room
         ST_PORT: begin
            if (pend_ff && (port_rd_data == item_ff.dst_port)) begin
               state_in = ST_UPD;
            end else if (pidx_ff == count_ff) begin
               if (count_ff < CNT_W'(PORTS_PER_TRACKER)) begin
                  port_wr_en = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
               end
               state_in = ST_UPD;
            end else begin
               pidx_in = pidx_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
         end
         // write back the record (unless the table was full) and load the result beat
         ST_UPD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (full_ff) begin
                  rsp_in = '0;
               end else begin
                  rec_wr_en           = 1'b1;
                  rsp_in.alert        = hit_alert;
                  rsp_in.tracked      = 1'b1;
                  rsp_in.unique_ports = 8'(count_ff);
                  rsp_in.slot_index   = 7'(slot_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff     <= scan_in;
      cmp_slot_ff <= cmp_slot_in;
      slot_ff     <= slot_in;
      full_ff     <= full_in;
      item_ff     <= item_in;
      start_ff    <= start_in;
      count_ff    <= count_in;
      alerted_ff  <= alerted_in;
      base_ff     <= base_in;
      pidx_ff     <= pidx_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // the table never holds more trackers than slots
   assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(NUM_TRACKERS))
      else $error("tracker fill count beyond table size");

   // trackers are claimed one at a time and never freed
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff != $past(fill_ff)) |-> (fill_ff == $past(fill_ff) + SCAN_W'(1)))
      else $error("tracker fill count moved by other than one");

   // an untracked result carries no alert, count or slot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.tracked) |->
         (!rsp_ff.alert && (rsp_ff.unique_ports == 8'd0) && (rsp_ff.slot_index == 7'd0)))
      else $error("untracked result with non-zero fields");

   // the port set never grows past its capacity
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PORT) |-> (32'(count_ff) <= 32'(PORTS_PER_TRACKER)))
      else $error("port count beyond set capacity");
`endif

endmodule

// ----- test/syn_port_scan_detector_top_test.sv -----
// syn_port_scan_detector_top_test: self-checking bench for the syn port scan detector
// drives syn event beats, predicts each verdict or takes it from the directed table, and compares it field by field
// depends on spd_pkg and syn_port_scan_detector_top
`timescale 1ns / 1ps

module syn_port_scan_detector_top_test
   import spd_pkg::*;
();

   localparam int NUM_SLOTS   = NUM_TRACKERS_DEF;
   localparam int SET_DEPTH   = PORTS_PER_TRACKER_DEF;
   localparam int IDLE_PCT    = 37;
   localparam int HOLD_CYCLES = 1500;
   localparam int STUCK_LIMIT = 6000;
   localparam int SETTLE_WAIT = NUM_SLOTS + SET_DEPTH + 20;

   // one row of the directed table; want is only meaningful when typed is set
   typedef struct packed {
      logic        typed;
      spd_req_type ev;
      spd_rsp_type want;
   } directed_row_type;

   // pairs: a = 0/0, b = all ones, d shares a's source, c = checker patterns
   localparam int NUM_ROWS = 22;
   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{1'b1, '{32'h0000_0000, 32'h0000_0000, 16'h0000, 32'h0000_0000}, '{1'b0, 1'b1, 8'd1,  7'd0}},
      '{1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF}, '{1'b0, 1'b1, 8'd1,  7'd1}},
      '{1'b1, '{32'h0000_0000, 32'h0000_0000, 16'h0000, 32'h0000_0000}, '{1'b0, 1'b1, 8'd1,  7'd0}},
      '{1'b1, '{32'h0000_0000, 32'h0000_0000, 16'hFFFF, 32'h0000_0005}, '{1'b0, 1'b1, 8'd2,  7'd0}},
      '{1'b1, '{32'h0000_0000, 32'h0000_0000, 16'h0001, 32'h0000_0006}, '{1'b0, 1'b1, 8'd1,  7'd0}},
      '{1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 32'h0000_0002}, '{1'b0, 1'b1, 8'd2,  7'd1}},
      '{1'b1, '{32'h0000_0000, 32'hFFFF_FFFF, 16'h0001, 32'h0000_0006}, '{1'b0, 1'b1, 8'd1,  7'd2}},
      '{1'b0, '{32'h0000_0000, 32'h0000_0000, 16'h0002, 32'h0000_0006}, '0},
      '{1'b0, '{32'h0000_0000, 32'h0000_0000, 16'h0003, 32'h0000_0006}, '0},
      '{1'b0, '{32'h0000_0000, 32'h0000_0000, 16'h0004, 32'h0000_0006}, '0},
      '{1'b0, '{32'h0000_0000, 32'h0000_0000, 16'h0005, 32'h0000_0006}, '0},
      '{1'b0, '{32'h0000_0000, 32'h0000_0000, 16'h0006, 32'h0000_0006}, '0},
      '{1'b0, '{32'h0000_0000, 32'h0000_0000, 16'h0007, 32'h0000_0006}, '0},
      '{1'b0, '{32'h0000_0000, 32'h0000_0000, 16'h0008, 32'h0000_0006}, '0},
      '{1'b0, '{32'h0000_0000, 32'h0000_0000, 16'h0009, 32'h0000_0006}, '0},
      '{1'b1, '{32'h0000_0000, 32'h0000_0000, 16'h000A, 32'h0000_0006}, '{1'b1, 1'b1, 8'd10, 7'd0}},
      '{1'b1, '{32'h0000_0000, 32'h0000_0000, 16'h000B, 32'h0000_0007}, '{1'b0, 1'b1, 8'd11, 7'd0}},
      '{1'b1, '{32'h0000_0000, 32'h0000_0000, 16'h000B, 32'h0000_000C}, '{1'b0, 1'b1, 8'd1,  7'd0}},
      '{1'b1, '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'h5A5A, 32'h8000_0000}, '{1'b0, 1'b1, 8'd1,  7'd3}},
      '{1'b1, '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'hA5A5, 32'h7FFF_FFFF}, '{1'b0, 1'b1, 8'd2,  7'd3}},
      '{1'b1, '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'h5A5A, 32'h8000_0005}, '{1'b0, 1'b1, 8'd2,  7'd3}},
      '{1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000}, '{1'b0, 1'b1, 8'd3,  7'd1}}
   };

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   spd_req_type           req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   spd_rsp_type           rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ALERT_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // tracker table as the block should hold it
   bit          trk_valid   [NUM_SLOTS];
   bit          trk_alerted [NUM_SLOTS];
   logic [31:0] trk_src     [NUM_SLOTS];
   logic [31:0] trk_dst     [NUM_SLOTS];
   logic [31:0] trk_start   [NUM_SLOTS];
   int          trk_count   [NUM_SLOTS];
   logic [15:0] trk_ports   [NUM_SLOTS][SET_DEPTH];
   int          trk_fill = 0;
   logic [7:0]  cfg_threshold = THRESHOLD_RESET;
   logic [15:0] cfg_window    = WINDOW_RESET;

   spd_rsp_type due_verdicts [$];
   logic [31:0] known_src [$];
   logic [31:0] known_dst [$];
   logic [31:0] sim_now;
   int          failures     = 0;
   int          stuck_cycles = 0;
   int          hold_left    = 0;
   bit          hold_off_due = 1'b0;
   bit          idling_on    = 1'b1;

   syn_port_scan_detector_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // verdict for one syn event; updates the tracker table
   task automatic track_syn_event(input spd_req_type ev, output spd_rsp_type verdict);
      int     slot;
      int     i;
      bit     hit;
      bit     seen;
      longint elapsed;
      longint win_len;
      verdict = '0;
      slot    = 0;
      hit     = 1'b0;
      for (i = 0; i < NUM_SLOTS; i++) begin
         if (!trk_valid[i]) begin
            trk_valid[i]   = 1'b1;
            trk_alerted[i] = 1'b0;
            trk_count[i]   = 0;
            trk_start[i]   = ev.time_sec;
            trk_src[i]     = ev.src_addr;
            trk_dst[i]     = ev.dst_addr;
            trk_fill++;
            slot = i;
            hit  = 1'b1;
            break;
         end
         if (trk_src[i] == ev.src_addr && trk_dst[i] == ev.dst_addr) begin
            slot = i;
            hit  = 1'b1;
            break;
         end
      end
      if (hit) begin
         // window expiry uses a signed difference, so older stamps never expire
         elapsed = longint'({32'd0, ev.time_sec}) - longint'({32'd0, trk_start[slot]});
         win_len = longint'({48'd0, cfg_window});
         if (elapsed > win_len) begin
            trk_count[slot]   = 0;
            trk_alerted[slot] = 1'b0;
            trk_start[slot]   = ev.time_sec;
         end
         seen = 1'b0;
         for (i = 0; i < trk_count[slot]; i++) begin
            if (trk_ports[slot][i] == ev.dst_port) seen = 1'b1;
         end
         if (!seen && trk_count[slot] < SET_DEPTH) begin
            trk_ports[slot][trk_count[slot]] = ev.dst_port;
            trk_count[slot]++;
         end
         if (trk_count[slot] >= int'(cfg_threshold) && !trk_alerted[slot]) begin
            trk_alerted[slot] = 1'b1;
            verdict.alert     = 1'b1;
         end
         verdict.tracked      = 1'b1;
         verdict.unique_ports = 8'(trk_count[slot]);
         verdict.slot_index   = 7'(slot);
      end
   endtask

   // offer one event beat, wait for it to be taken, then record its verdict
   task automatic send_event(input spd_req_type ev, input bit typed, input spd_rsp_type want);
      spd_rsp_type verdict;
      while (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (req_stall);
      track_syn_event(ev, verdict);
      due_verdicts.push_back(typed ? want : verdict);
   endtask

   // drop valid and wait until every verdict has come back
   task automatic finish_phase();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_verdicts.size() != 0) @(posedge clock);
   endtask

   // both registers, written back to back while the block is idle
   task automatic write_settings(input logic [7:0] thr, input logic [15:0] win);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ALERT_THRESHOLD;
      csr_wdata <= {8'($urandom), thr};
      @(negedge clock);
      csr_index <= CSR_WINDOW_SECONDS;
      csr_wdata <= win;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cfg_threshold = thr;
      cfg_window    = win;
   endtask

   // index of an address pair: a fresh one with new_pct percent, else a recent one
   function automatic int choose_pair(input int new_pct);
      int n;
      n = known_src.size();
      if (n == 0 || $urandom_range(0, 99) < new_pct) begin
         known_src.push_back($urandom);
         known_dst.push_back($urandom);
         // some fresh pairs share one address with a known pair
         if (n > 0 && $urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) == 0) known_src[n] = known_src[$urandom_range(0, n - 1)];
            else known_dst[n] = known_dst[$urandom_range(0, n - 1)];
         end
         return n;
      end
      if ($urandom_range(0, 99) < 70) return n - 1 - $urandom_range(0, (n > 8) ? 7 : n - 1);
      return $urandom_range(0, n - 1);
   endfunction

   // mostly scan bursts on one pair, some single events, some clock jumps
   task automatic run_traffic(input int n_items, input int new_pct);
      int          sent;
      int          kind;
      int          pick;
      int          burst_len;
      int          k;
      logic [15:0] base;
      spd_req_type ev;
      sent = 0;
      while (sent < n_items) begin
         kind        = $urandom_range(0, 99);
         pick        = choose_pair(new_pct);
         ev.src_addr = known_src[pick];
         ev.dst_addr = known_dst[pick];
         if (kind < 70) begin
            burst_len = $urandom_range(2, 14);
            base      = $urandom;
            for (k = 0; k < burst_len; k++) begin
               ev.dst_port = ($urandom_range(0, 4) == 0) ? base + 16'($urandom_range(0, k))
                                                         : base + 16'(k);
               sim_now     = sim_now + $urandom_range(0, 1);
               ev.time_sec = sim_now;
               send_event(ev, 1'b0, '0);
               sent++;
            end
         end else if (kind < 88) begin
            ev.dst_port = $urandom;
            sim_now     = sim_now + $urandom_range(0, 8);
            ev.time_sec = sim_now;
            send_event(ev, 1'b0, '0);
            sent++;
         end else begin
            // clock jumps: a wild stamp, or a step backwards
            ev.dst_port = $urandom;
            ev.time_sec = ($urandom_range(0, 1) == 0) ? $urandom
                                                      : sim_now - $urandom_range(1, 20);
            if ($urandom_range(0, 1) == 0) sim_now = ev.time_sec;
            send_event(ev, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // receiver stall: random, or one long hold-off on request
   always begin
      @(negedge clock);
      if (hold_off_due) begin
         hold_off_due = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idling_on && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // compare each verdict beat with the oldest one due
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_verdicts.size() == 0) begin
            $error("verdict beat with nothing due: %h", rsp_data);
            failures++;
         end else begin
            if (rsp_data.alert !== due_verdicts[0].alert) begin
               $error("alert: expected %0d, got %0d", due_verdicts[0].alert, rsp_data.alert);
               failures++;
            end
            if (rsp_data.tracked !== due_verdicts[0].tracked) begin
               $error("tracked: expected %0d, got %0d", due_verdicts[0].tracked,
                      rsp_data.tracked);
               failures++;
            end
            if (rsp_data.unique_ports !== due_verdicts[0].unique_ports) begin
               $error("unique_ports: expected %0d, got %0d", due_verdicts[0].unique_ports,
                      rsp_data.unique_ports);
               failures++;
            end
            if (rsp_data.slot_index !== due_verdicts[0].slot_index) begin
               $error("slot_index: expected %0d, got %0d", due_verdicts[0].slot_index,
                      rsp_data.slot_index);
               failures++;
            end
            void'(due_verdicts.pop_front());
         end
      end
   end

   // watchdog on cycles where no beat moves
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("syn_port_scan_detector_top_test NOT OK");
         $finish;
      end
   end

   initial begin
      int          r;
      int          k;
      int          pick;
      logic [15:0] base;
      spd_req_type ev;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows with reset settings
      for (r = 0; r < NUM_ROWS; r++)
         send_event(DIRECTED_ROWS[r].ev, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      finish_phase();
      sim_now = $urandom;

      // smallest threshold, zero-length window
      write_settings(8'd1, 16'd0);
      run_traffic(70, 15);
      finish_phase();

      // largest reachable threshold and largest window: one pair fills its port set under a long hold-off
      write_settings(8'd128, 16'hFFFF);
      hold_off_due = 1'b1;
      pick         = choose_pair(100);
      base         = $urandom;
      ev.src_addr  = known_src[pick];
      ev.dst_addr  = known_dst[pick];
      ev.time_sec  = sim_now;
      for (k = 0; k < SET_DEPTH + 7; k++) begin
         ev.dst_port = (k % 40 == 39) ? base : base + 16'(k);
         send_event(ev, 1'b0, '0);
      end
      run_traffic(25, 10);
      finish_phase();

      // threshold zero, no idling on either side
      write_settings(8'd0, WINDOW_RESET);
      idling_on = 1'b0;
      run_traffic(60, 15);
      finish_phase();
      idling_on = 1'b1;

      // threshold out of reach
      write_settings(8'hFF, 16'($urandom_range(1, 65534)));
      run_traffic(50, 15);
      finish_phase();

      // fill the tracker table, then keep offering fresh pairs
      write_settings(8'($urandom_range(2, 20)), 16'($urandom_range(1, 30)));
      while (trk_fill < NUM_SLOTS) begin
         pick        = choose_pair(($urandom_range(0, 4) == 0) ? 0 : 100);
         ev.src_addr = known_src[pick];
         ev.dst_addr = known_dst[pick];
         ev.dst_port = $urandom;
         sim_now     = sim_now + $urandom_range(0, 2);
         ev.time_sec = sim_now;
         send_event(ev, 1'b0, '0);
      end
      run_traffic(120, 30);
      finish_phase();

      repeat (SETTLE_WAIT) @(posedge clock);
      if (failures == 0)
         $display("syn_port_scan_detector_top_test OK");
      else
         $display("syn_port_scan_detector_top_test NOT OK");
      $finish;
   end

endmodule
